// ===== hdl/sync_header_xor_frame_receiver_defines.svh =====
// Assertion macros for the sync-header frame receiver.
`ifndef SYNC_HEADER_XOR_FRAME_RECEIVER_DEFINES_SVH
`define SYNC_HEADER_XOR_FRAME_RECEIVER_DEFINES_SVH

// Checked on every rising edge outside reset.
`define SHXFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SHXFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/shxfr_pkg.sv =====
// Types and constants for the sync-header frame receiver.
package shxfr_pkg;

  typedef enum logic [2:0] {
    PH_HDR1   = 3'd0,
    PH_HDR2   = 3'd1,
    PH_CMD    = 3'd2,
    PH_ADDR_L = 3'd3,
    PH_ADDR_H = 3'd4,
    PH_LEN    = 3'd5,
    PH_DATA   = 3'd6,
    PH_XOR    = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_DROP = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_BAD_CMD = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_MAX_LEN     = 2'd2
  } reg_idx_t;

  localparam logic [7:0] CMD_RD      = 8'h03;
  localparam logic [7:0] CMD_WR_ONE  = 8'h06;
  localparam logic [7:0] CMD_WR_MANY = 8'h10;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
  localparam logic [7:0] MAX_LEN_RST     = 8'd249;

  function automatic logic is_write_cmd(input logic [7:0] c);
    return (c == CMD_WR_ONE) || (c == CMD_WR_MANY);
  endfunction

endpackage

// ===== hdl/sync_header_xor_frame_receiver.sv =====
// Sync-header frame receiver: header hunt, frame parse, XOR check, result register.
// A result appears on out_* in the cycle after the word that causes it is accepted.
// Throughput: one word per cycle; in_stall rises only while a held result is stalled.
// Frame state and the result register update in the same cycle as input acceptance.
// Reset (rst_n low, synchronous): hunt for the first header byte, frame registers zero,
// configuration back to 0xAA / 0x55 / 249, output empty.
`include "sync_header_xor_frame_receiver_defines.svh"

module sync_header_xor_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_data_index,
  output logic [7:0]  out_command,
  output logic [15:0] out_address,
  output logic [7:0]  out_count,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  shxfr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  dcnt_r, dcnt_nxt;
  logic [7:0]  xor_r, xor_nxt;

  logic [7:0]  sync_first_r, sync_second_r, max_len_r;

  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_data_byte_r, out_data_index_r, out_command_r, out_count_r;
  logic [15:0] out_address_r;
  logic [1:0]  out_status_r;

  logic        in_acc;
  logic        res_valid;
  shxfr_pkg::kind_t   res_kind;
  shxfr_pkg::status_t res_status;
  logic [7:0]  res_data_byte, res_data_index;
  logic [7:0]  b;
  logic [8:0]  dcnt_inc;

  assign b         = in_rx_byte;
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign dcnt_inc  = {1'b0, dcnt_r} + 9'd1;

  // Next frame state
  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    addr_nxt  = addr_r;
    len_nxt   = len_r;
    dcnt_nxt  = dcnt_r;
    xor_nxt   = xor_r;
    unique case (phase_r)
      shxfr_pkg::PH_HDR1: begin
        if (b == sync_first_r) begin
          xor_nxt   = b;
          phase_nxt = shxfr_pkg::PH_HDR2;
        end
      end
      shxfr_pkg::PH_HDR2: begin
        if (b == sync_second_r) begin
          xor_nxt   = xor_r ^ b;
          phase_nxt = shxfr_pkg::PH_CMD;
        end else begin
          phase_nxt = shxfr_pkg::PH_HDR1;
        end
      end
      shxfr_pkg::PH_CMD: begin
        cmd_nxt   = b;
        xor_nxt   = xor_r ^ b;
        phase_nxt = shxfr_pkg::PH_ADDR_L;
      end
      shxfr_pkg::PH_ADDR_L: begin
        addr_nxt  = {addr_r[15:8], b};
        xor_nxt   = xor_r ^ b;
        phase_nxt = shxfr_pkg::PH_ADDR_H;
      end
      shxfr_pkg::PH_ADDR_H: begin
        addr_nxt  = {b, addr_r[7:0]};
        xor_nxt   = xor_r ^ b;
        phase_nxt = shxfr_pkg::PH_LEN;
      end
      shxfr_pkg::PH_LEN: begin
        len_nxt  = b;
        xor_nxt  = xor_r ^ b;
        dcnt_nxt = '0;
        if (b > max_len_r) begin
          phase_nxt = shxfr_pkg::PH_HDR1;
        end else if (shxfr_pkg::is_write_cmd(cmd_r) && (b != 8'd0)) begin
          phase_nxt = shxfr_pkg::PH_DATA;
        end else begin
          phase_nxt = shxfr_pkg::PH_XOR;
        end
      end
      shxfr_pkg::PH_DATA: begin
        xor_nxt  = xor_r ^ b;
        dcnt_nxt = dcnt_inc[7:0];
        if (dcnt_inc >= {1'b0, len_r}) begin
          phase_nxt = shxfr_pkg::PH_XOR;
        end
      end
      shxfr_pkg::PH_XOR: begin
        phase_nxt = shxfr_pkg::PH_HDR1;
      end
      default: phase_nxt = shxfr_pkg::PH_HDR1;
    endcase
  end

  // Result for the current word
  always_comb begin
    res_valid      = 1'b0;
    res_kind       = shxfr_pkg::KIND_DATA;
    res_status     = shxfr_pkg::ST_OK;
    res_data_byte  = '0;
    res_data_index = '0;
    unique case (phase_r)
      shxfr_pkg::PH_LEN: begin
        if (b > max_len_r) begin
          res_valid = 1'b1;
          res_kind  = shxfr_pkg::KIND_DROP;
        end
      end
      shxfr_pkg::PH_DATA: begin
        res_valid      = 1'b1;
        res_kind       = shxfr_pkg::KIND_DATA;
        res_data_byte  = b;
        res_data_index = dcnt_r;
      end
      shxfr_pkg::PH_XOR: begin
        res_valid = 1'b1;
        res_kind  = shxfr_pkg::KIND_DONE;
        // checksum wins over command check
        if (b != xor_r) begin
          res_status = shxfr_pkg::ST_BAD_SUM;
        end else if ((cmd_r == shxfr_pkg::CMD_RD) || shxfr_pkg::is_write_cmd(cmd_r)) begin
          res_status = shxfr_pkg::ST_OK;
        end else begin
          res_status = shxfr_pkg::ST_BAD_CMD;
        end
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= shxfr_pkg::PH_HDR1;
      cmd_r   <= '0;
      addr_r  <= '0;
      len_r   <= '0;
      dcnt_r  <= '0;
      xor_r   <= '0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      addr_r  <= addr_nxt;
      len_r   <= len_nxt;
      dcnt_r  <= dcnt_nxt;
      xor_r   <= xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= shxfr_pkg::SYNC_FIRST_RST;
      sync_second_r <= shxfr_pkg::SYNC_SECOND_RST;
      max_len_r     <= shxfr_pkg::MAX_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        shxfr_pkg::REG_SYNC_FIRST:  sync_first_r  <= cfg_data;
        shxfr_pkg::REG_SYNC_SECOND: sync_second_r <= cfg_data;
        shxfr_pkg::REG_MAX_LEN:     max_len_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= res_valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload loads only with a new result, so a stalled word holds
  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_kind_r       <= res_kind;
      out_data_byte_r  <= res_data_byte;
      out_data_index_r <= res_data_index;
      out_command_r    <= cmd_nxt;
      out_address_r    <= addr_nxt;
      out_count_r      <= len_nxt;
      out_status_r     <= res_status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_data_byte  = out_data_byte_r;
  assign out_data_index = out_data_index_r;
  assign out_command    = out_command_r;
  assign out_address    = out_address_r;
  assign out_count      = out_count_r;
  assign out_status     = out_status_r;

  `SHXFR_ASSERT_ALWAYS(a_no_stall_when_empty, !out_valid_r |-> !in_stall, "input stalled with empty output")
  `SHXFR_ASSERT(a_data_status_zero, (out_valid_r && out_kind_r == shxfr_pkg::KIND_DATA) |-> (out_status_r == shxfr_pkg::ST_OK), "data word carries nonzero status")
  `SHXFR_ASSERT(a_data_index_in_range, (out_valid_r && out_kind_r == shxfr_pkg::KIND_DATA) |-> (out_data_index_r < out_count_r), "data index beyond length")
  `SHXFR_ASSERT(a_frame_end_hunts, (in_acc && res_valid && res_kind != shxfr_pkg::KIND_DATA) |=> (phase_r == shxfr_pkg::PH_HDR1), "frame end did not return to hunt")

endmodule

// ===== tb/frame_rx_checker.sv =====
// Checker for the frame receiver: follows the byte stream, predicts result words, compares.
module frame_rx_checker
  import shxfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [7:0]  out_data_byte,
  input  logic [7:0]  out_data_index,
  input  logic [7:0]  out_command,
  input  logic [15:0] out_address,
  input  logic [7:0]  out_count,
  input  logic [1:0]  out_status,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [7:0]  data_index;
    logic [7:0]  command;
    logic [15:0] address;
    logic [7:0]  count;
    status_t     status;
  } frame_event_t;

  frame_event_t pending_results[$];
  int mismatches = 0;

  // Configuration as the block should hold it
  logic [7:0] hdr_first, hdr_second, len_limit;

  // Frame parser state
  phase_t      frame_phase;
  logic [7:0]  cur_cmd, cur_len, data_seen, xor_acc;
  logic [15:0] cur_addr;

  function automatic void push_result(kind_t k, logic [7:0] db, logic [7:0] di, status_t st);
    frame_event_t ev;
    ev.kind       = k;
    ev.data_byte  = db;
    ev.data_index = di;
    ev.command    = cur_cmd;
    ev.address    = cur_addr;
    ev.count      = cur_len;
    ev.status     = st;
    pending_results.push_back(ev);
  endfunction

  function automatic void parse_rx_byte(logic [7:0] b);
    status_t st;
    case (frame_phase)
      PH_HDR1: begin
        if (b == hdr_first) begin
          xor_acc     = b;
          frame_phase = PH_HDR2;
        end
      end
      PH_HDR2: begin
        // a failing byte goes back to the hunt without being tried as a first header
        if (b == hdr_second) begin
          xor_acc     = xor_acc ^ b;
          frame_phase = PH_CMD;
        end else begin
          frame_phase = PH_HDR1;
        end
      end
      PH_CMD: begin
        cur_cmd     = b;
        xor_acc     = xor_acc ^ b;
        frame_phase = PH_ADDR_L;
      end
      PH_ADDR_L: begin
        cur_addr[7:0] = b;
        xor_acc       = xor_acc ^ b;
        frame_phase   = PH_ADDR_H;
      end
      PH_ADDR_H: begin
        cur_addr[15:8] = b;
        xor_acc        = xor_acc ^ b;
        frame_phase    = PH_LEN;
      end
      PH_LEN: begin
        cur_len   = b;
        xor_acc   = xor_acc ^ b;
        data_seen = 8'd0;
        if (b > len_limit) begin
          frame_phase = PH_HDR1;
          push_result(KIND_DROP, 8'd0, 8'd0, ST_OK);
        end else if ((cur_cmd == CMD_WR_ONE || cur_cmd == CMD_WR_MANY) && b != 8'd0) begin
          frame_phase = PH_DATA;
        end else begin
          frame_phase = PH_XOR;
        end
      end
      PH_DATA: begin
        push_result(KIND_DATA, b, data_seen, ST_OK);
        xor_acc   = xor_acc ^ b;
        data_seen = data_seen + 8'd1;
        if (data_seen >= cur_len) frame_phase = PH_XOR;
      end
      default: begin
        // checksum wins over the command check
        if (b != xor_acc) st = ST_BAD_SUM;
        else if (cur_cmd == CMD_RD || cur_cmd == CMD_WR_ONE || cur_cmd == CMD_WR_MANY) st = ST_OK;
        else st = ST_BAD_CMD;
        frame_phase = PH_HDR1;
        push_result(KIND_DONE, 8'd0, 8'd0, st);
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("result field %s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    frame_event_t want;
    if (!rst_n) begin
      hdr_first   = SYNC_FIRST_RST;
      hdr_second  = SYNC_SECOND_RST;
      len_limit   = MAX_LEN_RST;
      frame_phase = PH_HDR1;
      cur_cmd     = 8'd0;
      cur_addr    = 16'd0;
      cur_len     = 8'd0;
      data_seen   = 8'd0;
      xor_acc     = 8'd0;
      pending_results.delete();
    end else begin
      // result side first, so a word pushed at this edge can't pair with it
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: kind %0d", out_kind);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("data_byte", want.data_byte, out_data_byte);
          check_field("data_index", want.data_index, out_data_index);
          check_field("command", want.command, out_command);
          check_field("address", want.address, out_address);
          check_field("count", want.count, out_count);
          check_field("status", want.status, out_status);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SYNC_FIRST:  hdr_first  = cfg_data;
          REG_SYNC_SECOND: hdr_second = cfg_data;
          REG_MAX_LEN:     len_limit  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) parse_rx_byte(in_rx_byte);
    end
    fail_count  <= mismatches;
    outstanding <= pending_results.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the frame receiver testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import shxfr_pkg::*;

  localparam logic [1:0] REG_UNUSED      = 2'd3;
  localparam logic [7:0] CMD_UNKNOWN     = 8'h42;
  localparam int         HOLD_OFF_CYCLES = 300;
  localparam int         CYCLE_LIMIT     = 600000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [7:0]  out_data_index;
  logic [7:0]  out_command;
  logic [15:0] out_address;
  logic [7:0]  out_count;
  logic [1:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_data = 8'd0;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int bytes_sent = 0;
  int target;

  bit sender_gappy = 1'b0;
  bit receiver_gappy = 1'b0;
  bit hold_off_req = 1'b0;

  // Stimulus copy of the configuration, used to build frames
  logic [7:0] hdr1_cfg = SYNC_FIRST_RST;
  logic [7:0] hdr2_cfg = SYNC_SECOND_RST;
  logic [7:0] limit_cfg = MAX_LEN_RST;

  sync_header_xor_frame_receiver dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_data_byte(out_data_byte), .out_data_index(out_data_index),
    .out_command(out_command), .out_address(out_address), .out_count(out_count),
    .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  frame_rx_checker frame_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_data_byte(out_data_byte), .out_data_index(out_data_index),
    .out_command(out_command), .out_address(out_address), .out_count(out_count),
    .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_stall <= 1'b0;
      end else if (receiver_gappy && $urandom_range(0, 99) < 25) begin
        out_stall <= 1'b1;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 2))
          @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!sender_gappy || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // Builds one frame under the current config; cut > 0 truncates it to that many bytes
  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] addr, input logic [7:0] len,
                            input bit corrupt, input int cut, input bit bad_hdr2);
    logic [7:0] frame_bytes[$];
    logic [7:0] sum;
    frame_bytes = {hdr1_cfg, bad_hdr2 ? hdr2_cfg ^ 8'($urandom_range(1, 255)) : hdr2_cfg,
                   cmd, addr[7:0], addr[15:8], len};
    if (len <= limit_cfg) begin
      if (cmd == CMD_WR_ONE || cmd == CMD_WR_MANY)
        repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
      sum = 8'd0;
      foreach (frame_bytes[i]) sum ^= frame_bytes[i];
      if (corrupt) sum ^= 8'($urandom_range(1, 255));
      frame_bytes.push_back(sum);
    end
    if (cut > 0)
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    bytes_sent += frame_bytes.size();
  endtask

  task automatic random_frame();
    logic [7:0] cmd, len;
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) cmd = CMD_WR_ONE;
    else if (r < 55) cmd = CMD_WR_MANY;
    else if (r < 75) cmd = CMD_RD;
    else cmd = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 12 && limit_cfg != 8'hFF) len = 8'($urandom_range(limit_cfg + 1, 255));
    else if (r < 15) len = 8'($urandom_range(0, limit_cfg));
    else len = 8'($urandom_range(0, (limit_cfg < 8) ? limit_cfg : 8));
    // line noise ahead of the frame
    if ($urandom_range(0, 99) < 10)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    send_frame(cmd, 16'($urandom_range(0, 65535)), len, $urandom_range(0, 99) < 15,
               ($urandom_range(0, 99) < 6) ? $urandom_range(1, 6) : 0,
               $urandom_range(0, 99) < 5);
  endtask

  task automatic random_phase(input int n);
    target = bytes_sent + n;
    while (bytes_sent < target) random_frame();
  endtask

  // Drain every expected word, then let the parser idle before touching config
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
    case (idx)
      REG_SYNC_FIRST:  hdr1_cfg  = val;
      REG_SYNC_SECOND: hdr2_cfg  = val;
      REG_MAX_LEN:     limit_cfg = val;
      default: ;
    endcase
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: second header fails on a first-header value, oversize drop,
    // write with data, read with a length, unknown command with a bad sum
    send_byte(SYNC_FIRST_RST);
    send_byte(SYNC_FIRST_RST);
    send_byte(SYNC_SECOND_RST);
    send_frame(CMD_WR_MANY, 16'h1234, 8'd250, 1'b0, 0, 1'b0);
    send_frame(CMD_WR_ONE, 16'hFFFF, 8'd2, 1'b0, 0, 1'b0);
    send_frame(CMD_RD, 16'h0000, 8'd5, 1'b0, 0, 1'b0);
    send_frame(CMD_UNKNOWN, 16'h8001, 8'd1, 1'b1, 0, 1'b0);

    sender_gappy = 1'b1;
    random_phase(300);
    settle();

    set_reg(REG_SYNC_FIRST, 8'h00);
    set_reg(REG_SYNC_SECOND, 8'hFF);
    set_reg(REG_MAX_LEN, 8'd0);
    sender_gappy   = 1'b0;
    receiver_gappy = 1'b1;
    random_phase(300);
    settle();

    set_reg(REG_SYNC_FIRST, 8'hFF);
    set_reg(REG_SYNC_SECOND, 8'h00);
    set_reg(REG_MAX_LEN, 8'd255);
    sender_gappy = 1'b1;
    send_frame(CMD_WR_MANY, 16'hA5C3, 8'd255, 1'b0, 0, 1'b0);
    random_phase(100);
    settle();

    // identical header bytes; index 3 must be ignored
    set_reg(REG_SYNC_FIRST, 8'h7E);
    set_reg(REG_SYNC_SECOND, 8'h7E);
    set_reg(REG_MAX_LEN, 8'd16);
    set_reg(REG_UNUSED, 8'h5A);
    receiver_gappy = 1'b0;
    random_phase(300);
    settle();

    set_reg(REG_SYNC_FIRST, 8'($urandom_range(0, 255)));
    set_reg(REG_SYNC_SECOND, 8'($urandom_range(0, 255)));
    set_reg(REG_MAX_LEN, 8'($urandom_range(1, 40)));
    sender_gappy = 1'b0;
    random_phase(300);
    settle();

    set_reg(REG_SYNC_FIRST, SYNC_FIRST_RST);
    set_reg(REG_SYNC_SECOND, SYNC_SECOND_RST);
    set_reg(REG_MAX_LEN, MAX_LEN_RST);
    // long result-side hold-off while a write streams in, so the input backs up
    hold_off_req = 1'b1;
    send_frame(CMD_WR_MANY, 16'h0F0F, 8'd40, 1'b0, 0, 1'b0);
    sender_gappy   = 1'b1;
    receiver_gappy = 1'b1;
    random_phase(250);
    settle();

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
